// ===== hw/rtl/vcra_pkg.sv =====
// ----------------------------------------------------------------------------
// vcra_pkg
// Shared types, codes and helpers of the variable chunk ring allocator.
// ----------------------------------------------------------------------------
package vcra_pkg;

	// sizing
	localparam int MAX_CHUNKS  = 16;
	localparam int DATA_BYTES  = 4096;
	localparam int SLOT_W      = $clog2(MAX_CHUNKS);
	localparam int CNT_W       = SLOT_W + 1;
	localparam int LEN_W       = 13;
	localparam int SLOTS_CFG_W = 5;
	localparam int UNREAD_W    = 4;
	localparam int CFG_W       = 13;

	// request codes
	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_PEEK  = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;

	// result status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_EMPTY    = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_NO_SPACE = 2'd3;

	// configuration register indexes
	localparam logic CFG_CHUNK_SLOTS   = 1'b0;
	localparam logic CFG_DATA_CAPACITY = 1'b1;

	typedef struct packed {
		logic [1:0]       req_type;
		logic [LEN_W-1:0] chunk_length;
	} req_t;

	typedef struct packed {
		logic [1:0]          status;
		logic [LEN_W-1:0]    chunk_offset;
		logic [LEN_W-1:0]    result_length;
		logic [UNREAD_W-1:0] unread_count;
	} rsp_t;

	// advance a descriptor slot, wrapping at the number of slots in use
	function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s,
			input logic [CNT_W-1:0] n);
		logic [CNT_W-1:0] t;
		t = {1'b0, s} + CNT_W'(1);
		return (t >= n) ? '0 : t[SLOT_W-1:0];
	endfunction

endpackage

// ===== hw/rtl/variable_chunk_ring_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// variable_chunk_ring_allocator_unit
// Descriptor and space manager of a FIFO of variable-length chunks.
// ----------------------------------------------------------------------------
// Usage
//   Requests enter on in_valid/in_ready with in_data (req_type, chunk_length).
//   A write allocates chunk_length bytes after the last chunk, or at offset
//   zero when it does not fit before the ring end but fits before the head.
//   Peek returns the head chunk; read returns it, popping it if length > 0.
//   Each request yields exactly one result on out_valid/out_ready with the
//   status, offset, length and the count of unread chunks.
//   An accepted request is captured in the request register, handled there
//   and its result is loaded into the result register that drives out_data.
//   Throughput: one request per cycle while the receiver takes results;
//   the descriptor state updates together with the result register.
//   When the receiver stalls, the result register holds and one further
//   request waits in the request register; in_ready then drops.
//   Reset empties the ring, clears all descriptors and sets chunk_slots to
//   16 and data_capacity to 4096. Configuration writes via cfg_we, cfg_index
//   and cfg_data take effect at once; the user must make them only while
//   idle, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
module variable_chunk_ring_allocator_unit import vcra_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  req_t             in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output rsp_t             out_data,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	// configuration registers
	logic [SLOTS_CFG_W-1:0] chunk_slots_q;
	logic [LEN_W-1:0]       data_capacity_q;

	// descriptor state
	logic [SLOT_W-1:0] write_slot_q;
	logic [SLOT_W-1:0] read_slot_q;
	logic [LEN_W-1:0]  woff_q;
	logic [LEN_W-1:0]  offs_q [MAX_CHUNKS];
	logic [LEN_W-1:0]  lens_q [MAX_CHUNKS];

	// request register and result register
	logic valid_s1;
	req_t req_s1;
	logic rsp_valid_q;
	rsp_t rsp_q;

	// handling signals
	logic              adv;
	logic [CNT_W-1:0]  n_slots;
	logic [LEN_W-1:0]  cap;
	logic [SLOT_W-1:0] nw;
	logic [SLOT_W-1:0] nr;
	logic [LEN_W-1:0]  roff;
	logic [LEN_W-1:0]  room;
	logic              wr_ok;
	logic              wr_wrap;
	logic [LEN_W-1:0]  base;
	logic [LEN_W-1:0]  end_off;
	logic              do_write;
	logic              do_read;
	logic [SLOT_W-1:0] w_next;
	logic [SLOT_W-1:0] r_next;
	logic [CNT_W-1:0]  diff;
	rsp_t              rsp_d;

	// stage handshake
	assign adv       = valid_s1 && (!rsp_valid_q || out_ready);
	assign in_ready  = !valid_s1 || adv;
	assign out_valid = rsp_valid_q;
	assign out_data  = rsp_q;

	// clamped configuration
	always_comb begin
		if (chunk_slots_q < SLOTS_CFG_W'(2)) begin
			n_slots = CNT_W'(2);
		end else if (chunk_slots_q > SLOTS_CFG_W'(MAX_CHUNKS)) begin
			n_slots = CNT_W'(MAX_CHUNKS);
		end else begin
			n_slots = CNT_W'(chunk_slots_q);
		end
		cap = (data_capacity_q > LEN_W'(DATA_BYTES)) ? LEN_W'(DATA_BYTES)
			: data_capacity_q;
	end

	// request handling
	always_comb begin
		nw      = next_slot(write_slot_q, n_slots);
		nr      = next_slot(read_slot_q, n_slots);
		roff    = offs_q[read_slot_q];
		room    = (woff_q < cap) ? (cap - woff_q) : '0;
		wr_ok   = 1'b1;
		wr_wrap = 1'b0;
		if (roff <= woff_q) begin
			if (req_s1.chunk_length > room) begin
				if (req_s1.chunk_length < roff) begin
					wr_wrap = 1'b1;
				end else begin
					wr_ok = 1'b0;
				end
			end
		end else if (req_s1.chunk_length >= (roff - woff_q)) begin
			wr_ok = 1'b0;
		end
		base    = wr_wrap ? '0 : woff_q;
		end_off = base + req_s1.chunk_length;

		do_write = 1'b0;
		do_read  = 1'b0;
		rsp_d.status        = ST_OK;
		rsp_d.chunk_offset  = '0;
		rsp_d.result_length = '0;
		if (req_s1.req_type == REQ_WRITE) begin
			if (nw == read_slot_q) begin
				rsp_d.status = ST_FULL;
			end else if (!wr_ok) begin
				rsp_d.status = ST_NO_SPACE;
			end else begin
				do_write            = 1'b1;
				rsp_d.chunk_offset  = base;
				rsp_d.result_length = req_s1.chunk_length;
			end
		end else if (read_slot_q == write_slot_q) begin
			rsp_d.status = ST_EMPTY;
		end else begin
			rsp_d.chunk_offset  = roff;
			rsp_d.result_length = lens_q[read_slot_q];
			do_read = (req_s1.req_type == REQ_READ) && (lens_q[read_slot_q] != '0);
		end

		// unread count after the request
		w_next = do_write ? nw : write_slot_q;
		r_next = do_read ? nr : read_slot_q;
		if (w_next >= r_next) begin
			diff = {1'b0, w_next} - {1'b0, r_next};
		end else begin
			diff = {1'b0, w_next} + n_slots - {1'b0, r_next};
		end
		rsp_d.unread_count = diff[UNREAD_W-1:0];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_slots_q   <= SLOTS_CFG_W'(MAX_CHUNKS);
			data_capacity_q <= LEN_W'(DATA_BYTES);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CHUNK_SLOTS:   chunk_slots_q   <= cfg_data[SLOTS_CFG_W-1:0];
				CFG_DATA_CAPACITY: data_capacity_q <= cfg_data[LEN_W-1:0];
				default:           ;
			endcase
		end
	end

	// request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1 <= in_data;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= 1'b1;
		end else if (out_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_q <= rsp_d;
		end
	end

	// descriptor state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_slot_q <= '0;
			read_slot_q  <= '0;
			woff_q       <= '0;
			for (int i = 0; i < MAX_CHUNKS; i++) begin
				offs_q[i] <= '0;
				lens_q[i] <= '0;
			end
		end else if (adv) begin
			if (do_write) begin
				offs_q[write_slot_q] <= base;
				lens_q[write_slot_q] <= req_s1.chunk_length;
				offs_q[nw]           <= end_off;
				write_slot_q         <= nw;
				woff_q               <= end_off;
			end
			if (do_read) begin
				read_slot_q <= nr;
			end
		end
	end

endmodule

// ===== hw/rtl/vcra_checker.sv =====
// ----------------------------------------------------------------------------
// vcra_port_checks
// Port-level checks of the variable chunk ring allocator.
// ----------------------------------------------------------------------------
module vcra_port_checks import vcra_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input req_t             in_data,
	input logic             out_valid,
	input logic             out_ready,
	input rsp_t             out_data,
	input logic             cfg_we,
	input logic             cfg_index,
	input logic [CFG_W-1:0] cfg_data
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// requests are only held off by a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("request side stalled without a waiting result");

	// empty ring reports no chunk
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ST_EMPTY |->
		out_data.chunk_offset == '0 && out_data.result_length == '0
		&& out_data.unread_count == '0)
		else $error("empty result carries chunk data");

	// refused write reports no chunk
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == ST_FULL || out_data.status == ST_NO_SPACE) |->
		out_data.chunk_offset == '0 && out_data.result_length == '0)
		else $error("refused write carries chunk data");

endmodule

bind variable_chunk_ring_allocator_unit vcra_port_checks u_vcra_port_checks (.*);
